// ===== rtl/core/qrs_pkg.sv =====
// Shared constants and root class codes of the quadratic root solver.
package qrs_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 20;
	localparam int OUT_WIDTH      = 40;

	localparam logic [1:0] CLS_NONE     = 2'd0;
	localparam logic [1:0] CLS_DISTINCT = 2'd1;
	localparam logic [1:0] CLS_EQUAL    = 2'd2;
	localparam logic [1:0] CLS_COMPLEX  = 2'd3;

endpackage

// ===== rtl/core/qrs_sqrt_cell.sv =====
// One restoring square root cell: it takes two radicand bits and settles one root bit.
module qrs_sqrt_cell
	import qrs_pkg::*;
#(
	parameter int SW = 37,
	parameter int XW = 74
) (
	input  logic          clk,
	input  logic          en,
	input  logic [SW+2:0] rem_i,
	input  logic [SW-1:0] root_i,
	input  logic [XW-1:0] rad_i,
	output logic [SW+2:0] rem_q,
	output logic [SW-1:0] root_q,
	output logic [XW-1:0] rad_q
);

	logic [SW+2:0] rem_t;
	logic [SW+2:0] trial;
	logic          ge;

	// The remainder never exceeds twice the root, so its top two bits are zero.
	always_comb begin
		rem_t = {rem_i[SW:0], rad_i[XW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = (rem_t >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? (rem_t - trial) : rem_t;
			root_q <= {root_i[SW-2:0], ge};
			rad_q  <= rad_i << 2;
		end
	end

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
// One restoring division cell for two numerators that share a divisor.
module qrs_div_cell
	import qrs_pkg::*;
#(
	parameter int NW  = 38,
	parameter int DNW = 17
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DNW-1:0] den_i,
	input  logic [NW-1:0]  n1_i,
	input  logic [NW-1:0]  n2_i,
	input  logic [NW-1:0]  q1_i,
	input  logic [NW-1:0]  q2_i,
	input  logic [DNW:0]   r1_i,
	input  logic [DNW:0]   r2_i,
	output logic [DNW-1:0] den_q,
	output logic [NW-1:0]  n1_q,
	output logic [NW-1:0]  n2_q,
	output logic [NW-1:0]  q1_q,
	output logic [NW-1:0]  q2_q,
	output logic [DNW:0]   r1_q,
	output logic [DNW:0]   r2_q
);

	logic [DNW:0] t1, t2, dx;
	logic         g1, g2;

	always_comb begin
		dx = {1'b0, den_i};
		t1 = {r1_i[DNW-1:0], n1_i[NW-1]};
		t2 = {r2_i[DNW-1:0], n2_i[NW-1]};
		g1 = (t1 >= dx);
		g2 = (t2 >= dx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_i;
			n1_q  <= n1_i << 1;
			n2_q  <= n2_i << 1;
			q1_q  <= {q1_i[NW-2:0], g1};
			q2_q  <= {q2_i[NW-2:0], g2};
			r1_q  <= g1 ? (t1 - dx) : t1;
			r2_q  <= g2 ? (t2 - dx) : t2;
		end
	end

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: front stages, square root and divider cell rows.
//
// Each input word carries a, b and c of a*x^2 + b*x + c as signed Q8.8 values and
// yields one result word: the root class, two signed Q20.20 values and a saturation
// flag. The discriminant b*b - 4ac is formed exactly. For real roots the values are
// (-b + sqrt(D))/2a and (-b - sqrt(D))/2a; for a complex pair they are -b/2a and
// sqrt(-D)/2|a|; a repeated root appears in both fields; when a is zero the class
// is "not quadratic" and all other fields are zero. Quotients truncate toward zero
// and values outside the 40-bit range clamp and set the flag. The block takes one
// word per clock cycle and is fully pipelined: two front stages (products, then the
// discriminant), one square root cell per root bit, a numerator stage, one divider
// cell per quotient bit, and the output register. The root has SW bits and each quotient
// has NW bits, where SW = (2*COEF_WIDTH + 2 + 2*RESULT_FRAC_BITS + 1)/2 and
// NW = max(COEF_WIDTH + RESULT_FRAC_BITS, SW) + 1; with the defaults they are 37 and 38.
// The whole pipeline advances together and halts only while a result word is held
// at the output, so in_ready is high whenever the output register is free or is
// being read in the same cycle.
module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int COEF_WIDTH       = COEF_WIDTH_DEF,
	parameter int RESULT_FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   root_class,
	output logic signed [OUT_WIDTH-1:0]  first_value,
	output logic signed [OUT_WIDTH-1:0]  second_value,
	output logic                         saturated
);

	localparam int W   = COEF_WIDTH;
	localparam int F   = RESULT_FRAC_BITS;
	localparam int DW  = 2 * W + 2;
	localparam int SW  = (DW + 2 * F + 1) / 2;
	localparam int XW  = 2 * SW;
	localparam int DNW = W + 1;
	localparam int BW  = W + F;
	localparam int NW  = ((BW > SW) ? BW : SW) + 1;
	localparam int OW  = OUT_WIDTH;
	localparam int CW  = ((NW > OW) ? NW : OW) + 1;
	localparam int SBW = 5 + DNW + BW;

	// The whole pipeline moves on together whenever the output register can take a word.
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Stage 1: coefficient magnitudes and the two products.
	logic [W-1:0] ua, ub, uc, ma, mb, mc;

	always_comb begin
		ua = coef_a;
		ub = coef_b;
		uc = coef_c;
		ma = ua[W-1] ? W'(~ua + 1'b1) : ua;
		mb = ub[W-1] ? W'(~ub + 1'b1) : ub;
		mc = uc[W-1] ? W'(~uc + 1'b1) : uc;
	end

	logic           v_s1;
	logic [W-1:0]   ma_s1, mb_s1;
	logic           na_s1, nb_s1, nc_s1;
	logic [2*W-1:0] bsq_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1  <= ma;
			mb_s1  <= mb;
			na_s1  <= ua[W-1];
			nb_s1  <= ub[W-1];
			nc_s1  <= uc[W-1];
			bsq_s1 <= mb * mb;
			ac_s1  <= ma * mc;
		end
	end

	// Stage 2: discriminant magnitude and sign, radicand scaled by 2^(2F).
	logic [DW-1:0] bsq_e, fac_e, dmag;
	logic          dneg;

	always_comb begin
		bsq_e = DW'(bsq_s1);
		fac_e = DW'(ac_s1) << 2;
		dneg  = 1'b0;
		if (na_s1 != nc_s1) begin
			dmag = bsq_e + fac_e;
		end else if (bsq_e >= fac_e) begin
			dmag = bsq_e - fac_e;
		end else begin
			dmag = fac_e - bsq_e;
			dneg = 1'b1;
		end
	end

	// Row of square root cells; index 0 is the stage 2 register.
	logic [SW:0]   sv;
	logic [SBW-1:0] sb   [SW+1];
	logic [SW+2:0]  srem [SW+1];
	logic [SW-1:0]  sroot[SW+1];
	logic [XW-1:0]  srad [SW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv[0] <= 1'b0;
		end else if (adv) begin
			sv[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb[0]    <= {(ma_s1 == '0), (dmag == '0), dneg, na_s1, ~nb_s1,
				DNW'(ma_s1) << 1, BW'(mb_s1) << F};
			srem[0]  <= '0;
			sroot[0] <= '0;
			srad[0]  <= XW'(dmag) << (2 * F);
		end
	end

	for (genvar k = 0; k < SW; k++) begin : g_sq
		qrs_sqrt_cell #(.SW(SW), .XW(XW)) u_cell (
			.clk    (clk),
			.en     (adv),
			.rem_i  (srem[k]),
			.root_i (sroot[k]),
			.rad_i  (srad[k]),
			.rem_q  (srem[k+1]),
			.root_q (sroot[k+1]),
			.rad_q  (srad[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[k+1] <= 1'b0;
			end else if (adv) begin
				sv[k+1] <= sv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sb[k+1] <= sb[k];
			end
		end
	end

	// Stage 3: signed numerators and the class.
	logic           azero3, dzero3, dneg3, na3, nbn3;
	logic [DNW-1:0] den3;
	logic [BW-1:0]  bf3;
	logic [NW-1:0]  bfx, sx, n1, n2;
	logic           g1, g2;
	logic [1:0]     cls3;

	assign {azero3, dzero3, dneg3, na3, nbn3, den3, bf3} = sb[SW];

	always_comb begin
		bfx = NW'(bf3);
		sx  = NW'(sroot[SW]);
		if (dzero3 || dneg3) begin
			n1 = bfx;
			g1 = nbn3 ^ na3;
			n2 = dzero3 ? bfx : sx;
			g2 = dzero3 ? g1 : 1'b0;
		end else begin
			// First root: -b*2^F + S.
			if (!nbn3) begin
				n1 = bfx + sx;
				g1 = na3;
			end else if (bfx >= sx) begin
				n1 = bfx - sx;
				g1 = ~na3;
			end else begin
				n1 = sx - bfx;
				g1 = na3;
			end
			// Second root: -b*2^F - S.
			if (nbn3) begin
				n2 = bfx + sx;
				g2 = ~na3;
			end else if (bfx >= sx) begin
				n2 = bfx - sx;
				g2 = na3;
			end else begin
				n2 = sx - bfx;
				g2 = ~na3;
			end
		end
		if (azero3) begin
			cls3 = CLS_NONE;
		end else if (dzero3) begin
			cls3 = CLS_EQUAL;
		end else if (dneg3) begin
			cls3 = CLS_COMPLEX;
		end else begin
			cls3 = CLS_DISTINCT;
		end
	end

	// Row of divider cells; index 0 is the stage 3 register.
	logic [NW:0]    dv;
	logic [3:0]     dsb [NW+1];
	logic [DNW-1:0] dden[NW+1];
	logic [NW-1:0]  dn1 [NW+1];
	logic [NW-1:0]  dn2 [NW+1];
	logic [NW-1:0]  dq1 [NW+1];
	logic [NW-1:0]  dq2 [NW+1];
	logic [DNW:0]   dr1 [NW+1];
	logic [DNW:0]   dr2 [NW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (adv) begin
			dv[0] <= sv[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsb[0]  <= {cls3, g1, g2};
			dden[0] <= den3;
			dn1[0]  <= n1;
			dn2[0]  <= n2;
			dq1[0]  <= '0;
			dq2[0]  <= '0;
			dr1[0]  <= '0;
			dr2[0]  <= '0;
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_dv
		qrs_div_cell #(.NW(NW), .DNW(DNW)) u_cell (
			.clk   (clk),
			.en    (adv),
			.den_i (dden[k]),
			.n1_i  (dn1[k]),
			.n2_i  (dn2[k]),
			.q1_i  (dq1[k]),
			.q2_i  (dq2[k]),
			.r1_i  (dr1[k]),
			.r2_i  (dr2[k]),
			.den_q (dden[k+1]),
			.n1_q  (dn1[k+1]),
			.n2_q  (dn2[k+1]),
			.q1_q  (dq1[k+1]),
			.q2_q  (dq2[k+1]),
			.r1_q  (dr1[k+1]),
			.r2_q  (dr2[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else if (adv) begin
				dv[k+1] <= dv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dsb[k+1] <= dsb[k];
			end
		end
	end

	// Output stage: clamp both quotients into the 40-bit result range.
	function automatic logic [OW:0] clamp(input logic [NW-1:0] q, input logic neg);
		logic [CW-1:0] qe, lim, m;
		logic          s;
		begin
			qe  = CW'(q);
			lim = neg ? (CW'(1) << (OW - 1)) : ((CW'(1) << (OW - 1)) - CW'(1));
			s   = (qe > lim);
			m   = s ? lim : qe;
			if (neg) begin
				m = ~m + CW'(1);
			end
			return {s, m[OW-1:0]};
		end
	endfunction

	logic [1:0]  cls_f;
	logic        g1_f, g2_f;
	logic [OW:0] c1, c2;

	always_comb begin
		{cls_f, g1_f, g2_f} = dsb[NW];
		c1 = clamp(dq1[NW], g1_f);
		c2 = clamp(dq2[NW], g2_f);
	end

	logic [1:0]    cls_q;
	logic [OW-1:0] v1_q, v2_q;
	logic          sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv[NW];
		end
	end

	// A missing quadratic term forces every other field to zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			cls_q <= cls_f;
			if (cls_f == CLS_NONE) begin
				v1_q  <= '0;
				v2_q  <= '0;
				sat_q <= 1'b0;
			end else begin
				v1_q  <= c1[OW-1:0];
				v2_q  <= c2[OW-1:0];
				sat_q <= c1[OW] | c2[OW];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign root_class   = cls_q;
	assign first_value  = v1_q;
	assign second_value = v2_q;
	assign saturated    = sat_q;

endmodule

// ===== rtl/core/qrs_checker.sv =====
// Port-level checker for the quadratic root solver and its bind statement.
module qrs_checker
	import qrs_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  root_class,
	input logic signed [OUT_WIDTH-1:0] first_value,
	input logic signed [OUT_WIDTH-1:0] second_value,
	input logic                        saturated
);

	// A result word that waits keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_value)
			&& $stable(second_value) && $stable(root_class) && $stable(saturated))
		else $error("result word changed while stalled");

	// The input side only stalls while a result word is held at the output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input stalled with a free output register");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_class == CLS_NONE |->
			first_value == '0 && second_value == '0 && !saturated)
		else $error("non-quadratic word carries values");

	a_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_class == CLS_EQUAL |-> first_value == second_value)
		else $error("repeated root differs between fields");

	a_imag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_class == CLS_COMPLEX |-> !second_value[OUT_WIDTH-1])
		else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.root_class   (root_class),
	.first_value  (first_value),
	.second_value (second_value),
	.saturated    (saturated)
);
